>>> rtl/core/rhp_pkg.sv
// rhp_pkg: shared types and constants for the RPC header parser.
// Depends on nothing; used by rhp_parse_core and rpc_header_parser_unit.
`timescale 1ns / 1ps

package rhp_pkg;

  localparam int unsigned PHASE_W = 3;
  localparam int unsigned BYTES_W = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned ERR_W   = 2;

  localparam logic [PHASE_W-1:0] PH_MASK   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_STREAM = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FUNC   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TMO    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_STATUS = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd5;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MASK  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TRUNC = 2'd2;
  localparam logic [ERR_W-1:0] ERR_LONG  = 2'd3;

  localparam logic [7:0] MASK_RSVD    = 8'hF0;
  localparam logic [7:0] MASK_REQUEST = 8'h01;
  localparam logic [7:0] MASK_FIRST   = 8'h02;
  localparam logic [7:0] MASK_LAST    = 8'h04;
  localparam logic [7:0] MASK_TIMEOUT = 8'h08;

  localparam logic [BYTES_W-1:0] BYTES_SAT    = 5'd31;
  localparam logic [IDX_W-1:0]   STREAM_LEN   = 4'd3;
  localparam logic [IDX_W-1:0]   VARINT_LAST  = 4'd9;
  localparam logic [IDX_W-1:0]   VARINT_LIMIT = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } rhp_in_t;

  typedef struct packed {
    logic               is_request;
    logic               first_message;
    logic               last_message;
    logic               timeout_present;
    logic [23:0]        stream_number;
    logic [63:0]        function_number;
    logic [31:0]        timeout_millis;
    logic [7:0]         status_code;
    logic [BYTES_W-1:0] header_bytes;
    logic [ERR_W-1:0]   parse_error;
    logic               timeout_clipped;
  } rhp_out_t;

endpackage

>>> rtl/core/rhp_chan_if.sv
// rhp_chan_if: valid/ready channel carrying one payload struct per transaction.
// Depends on nothing; its instances take payload types from rhp_pkg.
`timescale 1ns / 1ps

interface rhp_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/rhp_parse_core.sv
// rhp_parse_core: header parse state and per-byte field update logic.
// Depends on rhp_pkg; produces at most one result per accepted byte, combinationally.
`timescale 1ns / 1ps

module rhp_parse_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  rhp_pkg::rhp_in_t byte_in,
  output logic             res_valid,
  output rhp_pkg::rhp_out_t res
);
  import rhp_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [3:0]         flags_r, flags_nxt;
  logic [23:0]        stream_r, stream_nxt;
  logic [63:0]        func_r, func_nxt;
  logic [63:0]        tmo_r, tmo_nxt;
  logic [7:0]         status_r, status_nxt;

  logic [7:0]       b;
  logic             eob;
  logic             req_first;
  logic             resp_last;
  logic [IDX_W-1:0] idx_c;
  logic [IDX_W-1:0] idx_inc;
  logic [6:0]       shamt;
  logic [63:0]      vbits;
  logic             emit;
  logic [ERR_W-1:0] err;

  assign b         = byte_in.data_byte;
  assign eob       = byte_in.end_of_buffer;
  assign req_first = flags_r[0] && flags_r[1];
  assign resp_last = !flags_r[0] && flags_r[2];
  assign idx_c     = (idx_r > VARINT_LAST) ? VARINT_LAST : idx_r;
  assign idx_inc   = idx_c + 4'd1;
  assign shamt     = 7'(idx_c) * 7'd7;
  assign vbits     = {57'd0, b[6:0]} << shamt;

  always_comb begin
    phase_nxt  = phase_r;
    bytes_nxt  = bytes_r;
    idx_nxt    = idx_r;
    flags_nxt  = flags_r;
    stream_nxt = stream_r;
    func_nxt   = func_r;
    tmo_nxt    = tmo_r;
    status_nxt = status_r;
    emit       = 1'b0;
    err        = ERR_OK;

    if (phase_r == PH_SKIP) begin
      if (eob) begin
        phase_nxt = PH_MASK;
      end
    end else begin
      bytes_nxt = (bytes_r != BYTES_SAT) ? bytes_r + 5'd1 : bytes_r;
      unique case (phase_r)
        PH_STREAM: begin
          stream_nxt = {stream_r[15:0], b};
          idx_nxt    = idx_r + 4'd1;
          if (idx_nxt >= STREAM_LEN) begin
            idx_nxt = '0;
            if (req_first) begin
              phase_nxt = PH_FUNC;
            end else if (resp_last) begin
              phase_nxt = PH_STATUS;
            end else begin
              emit = 1'b1;
            end
          end
        end
        PH_FUNC, PH_TMO: begin
          if (phase_r == PH_FUNC) begin
            func_nxt = func_r | vbits;
          end else begin
            tmo_nxt = tmo_r | vbits;
          end
          idx_nxt = idx_inc;
          if (b[7]) begin
            if (idx_inc >= VARINT_LIMIT) begin
              emit = 1'b1;
              err  = ERR_LONG;
            end
          end else begin
            idx_nxt = '0;
            if (phase_r == PH_FUNC && flags_r[3]) begin
              phase_nxt = PH_TMO;
            end else begin
              emit = 1'b1;
            end
          end
        end
        PH_STATUS: begin
          status_nxt = b;
          emit       = 1'b1;
        end
        default: begin
          // mask byte; unused phase codes restart here as well
          bytes_nxt  = 5'd1;
          idx_nxt    = '0;
          flags_nxt  = '0;
          stream_nxt = '0;
          func_nxt   = '0;
          tmo_nxt    = '0;
          status_nxt = '0;
          if ((b & MASK_RSVD) != 8'h00) begin
            emit = 1'b1;
            err  = ERR_MASK;
          end else begin
            flags_nxt = b[3:0];
            phase_nxt = PH_STREAM;
          end
        end
      endcase
      if (!emit && eob) begin
        emit = 1'b1;
        err  = ERR_TRUNC;
      end
      if (emit) begin
        phase_nxt = eob ? PH_MASK : PH_SKIP;
      end
    end
  end

  always_comb begin
    res             = '0;
    res.parse_error = err;
    if (err == ERR_OK) begin
      res.is_request      = flags_nxt[0];
      res.first_message   = flags_nxt[1];
      res.last_message    = flags_nxt[2];
      res.timeout_present = flags_nxt[3];
      res.stream_number   = stream_nxt;
      res.function_number = func_nxt;
      res.timeout_millis  = tmo_nxt[31:0];
      res.status_code     = status_nxt;
      res.header_bytes    = bytes_nxt;
      res.timeout_clipped = |tmo_nxt[63:32];
    end
  end

  assign res_valid = step && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MASK;
      bytes_r <= '0;
      idx_r   <= '0;
      flags_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      bytes_r <= bytes_nxt;
      idx_r   <= idx_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      stream_r <= stream_nxt;
      func_r   <= func_nxt;
      tmo_r    <= tmo_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

>>> rtl/core/rpc_header_parser_unit.sv
// rpc_header_parser_unit: byte-serial RPC message header parser, top level.
// Depends on rhp_pkg, rhp_chan_if and rhp_parse_core.
//
//   channel   dir  payload                      transaction
//   in_chan   in   rhp_in_t  (one buffer byte)  valid & ready
//   out_chan  out  rhp_out_t (header result)    valid & ready
//
// One byte per cycle; a byte's result appears on out_chan the cycle after it is taken.
// The output register frees in the cycle its transaction completes, so no bubble.
// in_chan stalls only while a result is held and out_chan is not ready.
// Synchronous active-low reset returns the parser to waiting for a mask byte.
`timescale 1ns / 1ps

module rpc_header_parser_unit (
  input logic clk,
  input logic rst_n,
  rhp_chan_if.sink   in_chan,
  rhp_chan_if.source out_chan
);
  import rhp_pkg::*;

  logic     step;
  logic     res_valid;
  rhp_out_t res;
  logic     out_valid_r;
  rhp_out_t out_data_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign step          = in_chan.valid && in_chan.ready;

  rhp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (in_chan.payload),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

endmodule

>>> dv/rpc_header_parser_unit_tb.sv
// rpc_header_parser_unit_tb: byte-stream stimulus and self-checking scoreboard for the
// header parser; random valid/ready gaps on both channels. Depends on rhp_pkg,
// rhp_chan_if and rpc_header_parser_unit.
`timescale 1ns / 1ps

module rpc_header_parser_unit_tb;
  import rhp_pkg::*;

  localparam int PLAN_ITEMS   = 1950;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;

  class rhp_header_scoreboard;
    logic [PHASE_W-1:0] phase = PH_MASK;
    logic [BYTES_W-1:0] seen = '0;
    logic [IDX_W-1:0]   idx = '0;
    logic [3:0]         flags = '0;
    logic [23:0]        stream = '0;
    logic [63:0]        func = '0;
    logic [63:0]        tmo = '0;
    logic [7:0]         status = '0;
    rhp_out_t           expected_headers[$];
    int                 errors = 0;

    function void close_header(logic [ERR_W-1:0] err, logic eob);
      rhp_out_t r;
      r = '0;
      r.parse_error = err;
      if (err == ERR_OK) begin
        r.is_request      = flags[0];
        r.first_message   = flags[1];
        r.last_message    = flags[2];
        r.timeout_present = flags[3];
        r.stream_number   = stream;
        r.function_number = func;
        r.timeout_millis  = tmo[31:0];
        r.status_code     = status;
        r.header_bytes    = seen;
        r.timeout_clipped = (tmo[63:32] != 0);
      end
      expected_headers.push_back(r);
      phase = eob ? PH_MASK : PH_SKIP;
    endfunction

    function void note_byte(rhp_in_t item);
      logic [7:0]  b;
      logic        eob;
      logic        req_first;
      logic        resp_last;
      logic [63:0] chunk;
      b   = item.data_byte;
      eob = item.end_of_buffer;
      if (phase == PH_SKIP) begin
        if (eob) phase = PH_MASK;
        return;
      end
      if (phase > PH_SKIP) phase = PH_MASK;
      req_first = ((8'(flags) & MASK_REQUEST) != 0) && ((8'(flags) & MASK_FIRST) != 0);
      resp_last = ((8'(flags) & MASK_REQUEST) == 0) && ((8'(flags) & MASK_LAST) != 0);
      if (seen < BYTES_SAT) seen++;
      case (phase)
        PH_MASK: begin
          seen   = 5'd1;
          idx    = '0;
          flags  = '0;
          stream = '0;
          func   = '0;
          tmo    = '0;
          status = '0;
          if ((b & MASK_RSVD) != 0) begin
            close_header(ERR_MASK, eob);
            return;
          end
          flags = b[3:0];
          phase = PH_STREAM;
        end
        PH_STREAM: begin
          stream = {stream[15:0], b};
          idx++;
          if (idx >= STREAM_LEN) begin
            idx = '0;
            if (req_first) begin
              phase = PH_FUNC;
            end else if (resp_last) begin
              phase = PH_STATUS;
            end else begin
              close_header(ERR_OK, eob);
              return;
            end
          end
        end
        PH_FUNC, PH_TMO: begin
          if (idx > VARINT_LAST) idx = VARINT_LAST;
          chunk = 64'(b[6:0]) << (7 * 32'(idx));
          if (phase == PH_FUNC) func = func | chunk;
          else tmo = tmo | chunk;
          idx++;
          if (b[7]) begin
            if (idx >= VARINT_LIMIT) begin
              close_header(ERR_LONG, eob);
              return;
            end
          end else begin
            idx = '0;
            if (phase == PH_FUNC && (8'(flags) & MASK_TIMEOUT) != 0) begin
              phase = PH_TMO;
            end else begin
              close_header(ERR_OK, eob);
              return;
            end
          end
        end
        default: begin
          status = b;
          close_header(ERR_OK, eob);
          return;
        end
      endcase
      if (eob) close_header(ERR_TRUNC, eob);
    endfunction

    function void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_header(rhp_out_t got);
      rhp_out_t want;
      if (expected_headers.size() == 0) begin
        $error("result transaction with no header pending");
        errors++;
        return;
      end
      want = expected_headers.pop_front();
      check_field("is_request", 64'(want.is_request), 64'(got.is_request));
      check_field("first_message", 64'(want.first_message), 64'(got.first_message));
      check_field("last_message", 64'(want.last_message), 64'(got.last_message));
      check_field("timeout_present", 64'(want.timeout_present), 64'(got.timeout_present));
      check_field("stream_number", 64'(want.stream_number), 64'(got.stream_number));
      check_field("function_number", want.function_number, got.function_number);
      check_field("timeout_millis", 64'(want.timeout_millis), 64'(got.timeout_millis));
      check_field("status_code", 64'(want.status_code), 64'(got.status_code));
      check_field("header_bytes", 64'(want.header_bytes), 64'(got.header_bytes));
      check_field("parse_error", 64'(want.parse_error), 64'(got.parse_error));
      check_field("timeout_clipped", 64'(want.timeout_clipped), 64'(got.timeout_clipped));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic steady = 1'b0;
  int   idle_cycles = 0;
  int   planned_items = 0;

  rhp_in_t    byte_plan[$];
  logic [7:0] header_plan[$];
  rhp_header_scoreboard sb;

  rhp_chan_if #(.payload_t(rhp_in_t))  in_chan ();
  rhp_chan_if #(.payload_t(rhp_out_t)) out_chan ();

  rpc_header_parser_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  function int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function void plan_byte(logic [7:0] b, logic eob);
    byte_plan.push_back({b, eob});
    planned_items++;
  endfunction

  // returns 1 when the varint runs past ten bytes
  function bit plan_varint();
    int len;
    bit overlong;
    overlong = ($urandom_range(0, 24) == 0);
    if (overlong) len = 10;
    else if ($urandom_range(0, 9) < 6) len = $urandom_range(1, 3);
    else len = $urandom_range(4, 10);
    for (int i = 0; i < len; i++) begin
      header_plan.push_back({(i < len - 1) || overlong, 7'($urandom)});
    end
    return overlong;
  endfunction

  function void plan_message();
    logic [7:0] mask;
    int         kind;
    int         cut;
    int         payload_len;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) plan_byte(8'($urandom), 1'($urandom));
      return;
    end
    mask = {4'h0, 4'($urandom)};
    case ($urandom_range(0, 3))
      0, 1: mask = mask | MASK_REQUEST | MASK_FIRST;
      2: mask = (mask & ~MASK_REQUEST) | MASK_LAST;
      default: ;
    endcase
    if (kind < 12) mask = mask | {4'($urandom_range(1, 15)), 4'h0};
    header_plan.delete();
    header_plan.push_back(mask);
    repeat (3) header_plan.push_back(8'($urandom));
    if ((mask & (MASK_REQUEST | MASK_FIRST)) == (MASK_REQUEST | MASK_FIRST)) begin
      if (!plan_varint() && (mask & MASK_TIMEOUT) != 0) void'(plan_varint());
    end else if ((mask & (MASK_REQUEST | MASK_LAST)) == MASK_LAST) begin
      header_plan.push_back(8'($urandom));
    end
    if (kind < 22) begin
      cut = $urandom_range(1, header_plan.size() - 1);
      for (int i = 0; i < cut; i++) plan_byte(header_plan[i], i == cut - 1);
      return;
    end
    payload_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 12);
    for (int i = 0; i < header_plan.size(); i++) begin
      plan_byte(header_plan[i], payload_len == 0 && i == header_plan.size() - 1);
    end
    for (int i = 0; i < payload_len; i++) begin
      plan_byte(8'($urandom), i == payload_len - 1);
    end
  endfunction

  function void plan_directed();
    // reserved mask bits, then payload skip
    plan_byte(8'hFF, 1'b0);
    plan_byte(8'h00, 1'b1);
    // non-first request ends after the stream id
    plan_byte(8'h01, 1'b0);
    repeat (2) plan_byte(8'hFF, 1'b0);
    plan_byte(8'hFF, 1'b1);
    // last response with timeout flag: status only, no timeout read
    plan_byte(8'h0C, 1'b0);
    repeat (3) plan_byte(8'h00, 1'b0);
    plan_byte(8'hFF, 1'b1);
    // truncated inside the stream id
    plan_byte(8'h03, 1'b0);
    plan_byte(8'hAB, 1'b1);
    // first request, two-byte function id, timeout
    plan_byte(8'h0B, 1'b0);
    plan_byte(8'h12, 1'b0);
    plan_byte(8'h34, 1'b0);
    plan_byte(8'h56, 1'b0);
    plan_byte(8'h80, 1'b0);
    plan_byte(8'h01, 1'b0);
    plan_byte(8'h7F, 1'b1);
    // ten continuation bytes: too long wins over truncation
    plan_byte(8'h03, 1'b0);
    repeat (3) plan_byte(8'h00, 1'b0);
    repeat (9) plan_byte(8'hFF, 1'b0);
    plan_byte(8'hFF, 1'b1);
  endfunction

  task drive_bytes();
    int gap;
    foreach (byte_plan[i]) begin
      gap = pick_gap();
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_chan.valid   <= 1'b1;
      in_chan.payload <= byte_plan[i];
      do @(posedge clk); while (!in_chan.ready);
    end
    in_chan.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) sb.note_byte(in_chan.payload);
      if (out_chan.valid && out_chan.ready) sb.check_header(out_chan.payload);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(150, 400)) @(posedge clk);
      steady <= 1'b1;
      repeat ($urandom_range(50, 150)) @(posedge clk);
      steady <= 1'b0;
    end
  end

  initial begin
    int gap;
    out_chan.ready = 1'b0;
    forever begin
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("rpc_header_parser_unit_tb: errors");
    $finish;
  end

  initial begin
    in_chan.valid   = 1'b0;
    in_chan.payload = '0;
    sb = new();
    plan_directed();
    while (planned_items < PLAN_ITEMS) plan_message();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    drive_bytes();
    @(negedge clk);
    while (sb.expected_headers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_headers.size() != 0) begin
      $error("%0d header results never arrived", sb.expected_headers.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("rpc_header_parser_unit_tb: clean");
    end else begin
      $display("rpc_header_parser_unit_tb: errors");
    end
    $finish;
  end

endmodule
